/* sv/ffa_pkg.sv */
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int DEF_CHUNK_SLOTS = 16;
  localparam int DEF_OFFSET_BITS = 20;

  localparam int REQ_SIZE_W  = 21;
  localparam int ADDR_W      = 20;
  localparam int SZ_W        = 22;
  localparam int STATUS_W    = 3;
  localparam int BYTES_W     = 21;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 21;
  localparam int ALIGN_W     = 4;

  localparam int ARENA_RESET = 262144;
  localparam int ALIGN_RESET = 4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ARENA = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALIGN = 1'd1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic best_hit;
    logic prev_hit;
    logic next_hit;
    logic fhole_hit;
    logic uhole_hit;
    logic match_hit;
  } scan_flags_t;

endpackage

/* sv/ffa_ram.sv */
`timescale 1ns / 1ps

module ffa_ram import ffa_pkg::*; #(
  parameter int DEPTH  = DEF_CHUNK_SLOTS,
  parameter int IDX_W  = 4,
  parameter int BASE_W = DEF_OFFSET_BITS,
  parameter int LEN_W  = DEF_OFFSET_BITS + 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [BASE_W-1:0] wbase,
  input  logic [LEN_W-1:0]  wlen,
  input  logic [IDX_W-1:0]  raddr,
  output logic [BASE_W-1:0] rbase,
  output logic [LEN_W-1:0]  rlen
);

  logic [BASE_W+LEN_W-1:0] mem [DEPTH];
  logic [BASE_W+LEN_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wbase, wlen};
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  assign rbase = rdata[BASE_W+LEN_W-1:LEN_W];
  assign rlen  = rdata[LEN_W-1:0];

endmodule

/* sv/ffa_scan.sv */
`timescale 1ns / 1ps

module ffa_scan import ffa_pkg::*; #(
  parameter int IDX_W  = 4,
  parameter int BASE_W = DEF_OFFSET_BITS,
  parameter int LEN_W  = DEF_OFFSET_BITS + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              en,
  input  logic [IDX_W-1:0]  slot,
  input  logic              fv,
  input  logic [BASE_W-1:0] fbase,
  input  logic [LEN_W-1:0]  flen,
  input  logic              uv,
  input  logic [BASE_W-1:0] ubase,
  input  logic [LEN_W-1:0]  ulen,
  input  logic [BASE_W-1:0] fb,
  input  logic              addr_fits,
  input  logic [SZ_W-1:0]   sz,
  output scan_flags_t       flags,
  output logic [IDX_W-1:0]  best_idx,
  output logic [BASE_W-1:0] best_base,
  output logic [LEN_W-1:0]  best_len,
  output logic [IDX_W-1:0]  prev_idx,
  output logic [BASE_W-1:0] prev_base,
  output logic [LEN_W-1:0]  prev_len,
  output logic [IDX_W-1:0]  next_idx,
  output logic [BASE_W-1:0] next_base,
  output logic [LEN_W-1:0]  next_len,
  output logic [IDX_W-1:0]  fhole_idx,
  output logic [IDX_W-1:0]  uhole_idx,
  output logic [IDX_W-1:0]  match_idx,
  output logic [LEN_W-1:0]  match_len
);

  localparam int SCMP_W = (LEN_W > SZ_W) ? LEN_W : SZ_W;

  logic fit;
  logic below;
  logic take_best;
  logic take_prev;
  logic take_next;
  logic take_fhole;
  logic take_uhole;
  logic take_match;

  always_comb begin
    fit        = fv && (SCMP_W'(flen) >= SCMP_W'(sz));
    below      = fbase <= fb;
    take_best  = fit && (!flags.best_hit || fbase < best_base);
    take_prev  = fv && below && (!flags.prev_hit || fbase > prev_base);
    take_next  = fv && !below && (!flags.next_hit || fbase < next_base);
    take_fhole = !fv && !flags.fhole_hit;
    take_uhole = !uv && !flags.uhole_hit;
    take_match = uv && addr_fits && (ubase == fb) && !flags.match_hit;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      flags <= '0;
    end else if (en) begin
      flags.best_hit  <= flags.best_hit  | take_best;
      flags.prev_hit  <= flags.prev_hit  | take_prev;
      flags.next_hit  <= flags.next_hit  | take_next;
      flags.fhole_hit <= flags.fhole_hit | take_fhole;
      flags.uhole_hit <= flags.uhole_hit | take_uhole;
      flags.match_hit <= flags.match_hit | take_match;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (take_best) begin
        best_idx  <= slot;
        best_base <= fbase;
        best_len  <= flen;
      end
      if (take_prev) begin
        prev_idx  <= slot;
        prev_base <= fbase;
        prev_len  <= flen;
      end
      if (take_next) begin
        next_idx  <= slot;
        next_base <= fbase;
        next_len  <= flen;
      end
      if (take_fhole) begin
        fhole_idx <= slot;
      end
      if (take_uhole) begin
        uhole_idx <= slot;
      end
      if (take_match) begin
        match_idx <= slot;
        match_len <= ulen;
      end
    end
  end

endmodule

/* sv/first_fit_arena_allocator.sv */
// One request at a time: in_stall holds off a new request until the result word is
// committed, after the single scan of both chunk tables at one slot per cycle.
// Reset (synchronous, active high) restores a 262144-byte arena as one free
// chunk, alignment 16, empty used table; there is no clearing pass.
`timescale 1ns / 1ps

module first_fit_arena_allocator import ffa_pkg::*; #(
  parameter int CHUNK_SLOTS = DEF_CHUNK_SLOTS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [REQ_SIZE_W-1:0]  req_size,
  input  logic [ADDR_W-1:0]      req_addr,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [ADDR_W-1:0]      addr_out,
  output logic [BYTES_W-1:0]     used_bytes,
  output logic [BYTES_W-1:0]     free_bytes,
  output logic [COUNT_W-1:0]     used_count,
  output logic [COUNT_W-1:0]     free_count,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W   = $clog2(CHUNK_SLOTS);
  localparam int CNT_W   = $clog2(CHUNK_SLOTS + 1);
  localparam int BASE_W  = OFFSET_BITS;
  localparam int LEN_W   = OFFSET_BITS + 1;
  localparam int SUM_W   = LEN_W + 1;
  localparam int AX_W    = (ADDR_W > BASE_W) ? ADDR_W : BASE_W;
  localparam int ARENA_W = (CFG_DATA_W > LEN_W) ? CFG_DATA_W : LEN_W;

  localparam logic [ARENA_W-1:0] ARENA_MAX = ARENA_W'(1) << OFFSET_BITS;
  localparam logic [ARENA_W-1:0] ARENA_RST_RAW = ARENA_W'(ARENA_RESET);
  localparam logic [LEN_W-1:0] ARENA_RST =
    LEN_W'((ARENA_RST_RAW > ARENA_MAX) ? ARENA_MAX : ARENA_RST_RAW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CHUNK_SLOTS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_CALC   = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [CNT_W-1:0]       cnt;
  logic                   rd_en_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic                   req_free;
  logic [SZ_W-1:0]        sz_q;
  logic [BASE_W-1:0]      fb_q;
  logic                   fits_q;
  logic [LEN_W-1:0]       arena_bytes;
  logic [ALIGN_W-1:0]     align_log2;
  logic [CHUNK_SLOTS-1:0] free_valid;
  logic [CHUNK_SLOTS-1:0] used_valid;
  logic                   fresh;
  logic [LEN_W-1:0]       used_total;
  logic [LEN_W-1:0]       free_total;
  logic [CNT_W-1:0]       used_cnt;
  logic [CNT_W-1:0]       free_cnt;
  logic [LEN_W-1:0]       alloc_addr;
  logic [LEN_W-1:0]       alloc_rem;
  logic                   join_prev;
  logic                   join_next;

  logic                   accept;
  logic                   commit;
  logic [SZ_W-1:0]        align_mask;
  logic [SZ_W-1:0]        sz_calc;
  logic [ARENA_W-1:0]     cfg_ext;
  logic [LEN_W-1:0]       arena_new;
  logic [IDX_W-1:0]       rd_addr;

  logic [BASE_W-1:0]      fram_base;
  logic [LEN_W-1:0]       fram_len;
  logic [BASE_W-1:0]      uram_base;
  logic [LEN_W-1:0]       uram_len;
  logic [BASE_W-1:0]      fr_base;
  logic [LEN_W-1:0]       fr_len;

  scan_flags_t            flags;
  logic [IDX_W-1:0]       best_idx;
  logic [BASE_W-1:0]      best_base;
  logic [LEN_W-1:0]       best_len;
  logic [IDX_W-1:0]       prev_idx;
  logic [BASE_W-1:0]      prev_base;
  logic [LEN_W-1:0]       prev_len;
  logic [IDX_W-1:0]       next_idx;
  logic [BASE_W-1:0]      next_base;
  logic [LEN_W-1:0]       next_len;
  logic [IDX_W-1:0]       fhole_idx;
  logic [IDX_W-1:0]       uhole_idx;
  logic [IDX_W-1:0]       match_idx;
  logic [LEN_W-1:0]       match_len;

  logic [STATUS_W-1:0]    st;
  logic                   free_we;
  logic [IDX_W-1:0]       free_waddr;
  logic [BASE_W-1:0]      free_wbase;
  logic [LEN_W-1:0]       free_wlen;
  logic                   used_we;
  logic                   fv_we;
  logic [IDX_W-1:0]       fv_idx;
  logic                   fv_val;
  logic                   uv_we;
  logic [IDX_W-1:0]       uv_idx;
  logic                   uv_val;
  logic [LEN_W-1:0]       used_total_next;
  logic [LEN_W-1:0]       free_total_next;
  logic [CNT_W-1:0]       used_cnt_next;
  logic [CNT_W-1:0]       free_cnt_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == S_DECIDE) && (!out_valid || !out_stall);
  assign rd_addr  = cnt[IDX_W-1:0];

  always_comb begin
    align_mask = (SZ_W'(1) << align_log2) - SZ_W'(1);
    sz_calc    = (SZ_W'(req_size) + align_mask) & ~align_mask;
    cfg_ext    = ARENA_W'(cfg_data);
    arena_new  = LEN_W'((cfg_ext > ARENA_MAX) ? ARENA_MAX : cfg_ext);
  end

  always_comb begin
    if (fresh && rd_idx_q == '0) begin
      fr_base = '0;
      fr_len  = arena_bytes;
    end else begin
      fr_base = fram_base;
      fr_len  = fram_len;
    end
  end

  ffa_ram #(
    .DEPTH  (CHUNK_SLOTS),
    .IDX_W  (IDX_W),
    .BASE_W (BASE_W),
    .LEN_W  (LEN_W)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we && commit),
    .waddr (free_waddr),
    .wbase (free_wbase),
    .wlen  (free_wlen),
    .raddr (rd_addr),
    .rbase (fram_base),
    .rlen  (fram_len)
  );

  ffa_ram #(
    .DEPTH  (CHUNK_SLOTS),
    .IDX_W  (IDX_W),
    .BASE_W (BASE_W),
    .LEN_W  (LEN_W)
  ) u_used_ram (
    .clk   (clk),
    .we    (used_we && commit),
    .waddr (uhole_idx),
    .wbase (BASE_W'(alloc_addr)),
    .wlen  (LEN_W'(sz_q)),
    .raddr (rd_addr),
    .rbase (uram_base),
    .rlen  (uram_len)
  );

  ffa_scan #(
    .IDX_W  (IDX_W),
    .BASE_W (BASE_W),
    .LEN_W  (LEN_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clr       (accept),
    .en        ((state == S_SCAN) && rd_en_q),
    .slot      (rd_idx_q),
    .fv        (free_valid[rd_idx_q]),
    .fbase     (fr_base),
    .flen      (fr_len),
    .uv        (used_valid[rd_idx_q]),
    .ubase     (uram_base),
    .ulen      (uram_len),
    .fb        (fb_q),
    .addr_fits (fits_q),
    .sz        (sz_q),
    .flags     (flags),
    .best_idx  (best_idx),
    .best_base (best_base),
    .best_len  (best_len),
    .prev_idx  (prev_idx),
    .prev_base (prev_base),
    .prev_len  (prev_len),
    .next_idx  (next_idx),
    .next_base (next_base),
    .next_len  (next_len),
    .fhole_idx (fhole_idx),
    .uhole_idx (uhole_idx),
    .match_idx (match_idx),
    .match_len (match_len)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == LAST) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    st              = ST_OK;
    free_we         = 1'b0;
    free_waddr      = best_idx;
    free_wbase      = best_base;
    free_wlen       = alloc_rem;
    used_we         = 1'b0;
    fv_we           = 1'b0;
    fv_idx          = best_idx;
    fv_val          = 1'b0;
    uv_we           = 1'b0;
    uv_idx          = uhole_idx;
    uv_val          = 1'b1;
    used_total_next = used_total;
    free_total_next = free_total;
    used_cnt_next   = used_cnt;
    free_cnt_next   = free_cnt;
    if (!req_free) begin
      priority if (sz_q == '0) begin
        st = ST_ZERO_SIZE;
      end else if (!flags.best_hit) begin
        st = ST_NO_FIT;
      end else if (!flags.uhole_hit) begin
        st = ST_TABLE_FULL;
      end else begin
        free_we         = 1'b1;
        used_we         = 1'b1;
        uv_we           = 1'b1;
        fv_we           = (alloc_rem == '0);
        used_total_next = used_total + LEN_W'(sz_q);
        free_total_next = free_total - LEN_W'(sz_q);
        used_cnt_next   = used_cnt + CNT_W'(1);
        free_cnt_next   = free_cnt - CNT_W'(alloc_rem == '0);
      end
    end else begin
      priority if (!flags.match_hit) begin
        st = ST_BAD_FREE;
      end else if (!join_prev && !join_next && !flags.fhole_hit) begin
        st = ST_TABLE_FULL;
      end else begin
        free_we         = 1'b1;
        uv_we           = 1'b1;
        uv_idx          = match_idx;
        uv_val          = 1'b0;
        used_total_next = used_total - match_len;
        free_total_next = free_total + match_len;
        used_cnt_next   = used_cnt - CNT_W'(1);
        priority if (join_prev) begin
          free_waddr = prev_idx;
          free_wbase = prev_base;
          free_wlen  = prev_len + match_len + (join_next ? next_len : '0);
          fv_we      = join_next;
          fv_idx     = next_idx;
          fv_val     = 1'b0;
          free_cnt_next = free_cnt - CNT_W'(join_next);
        end else if (join_next) begin
          free_waddr = next_idx;
          free_wbase = fb_q;
          free_wlen  = match_len + next_len;
        end else begin
          free_waddr    = fhole_idx;
          free_wbase    = fb_q;
          free_wlen     = match_len;
          fv_we         = 1'b1;
          fv_idx        = fhole_idx;
          fv_val        = 1'b1;
          free_cnt_next = free_cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      rd_en_q     <= 1'b0;
      out_valid   <= 1'b0;
      arena_bytes <= ARENA_RST;
      align_log2  <= ALIGN_W'(ALIGN_RESET);
      free_valid  <= CHUNK_SLOTS'(ARENA_RST != '0);
      used_valid  <= '0;
      fresh       <= 1'b1;
      used_total  <= '0;
      free_total  <= ARENA_RST;
      used_cnt    <= '0;
      free_cnt    <= CNT_W'(ARENA_RST != '0);
    end else begin
      state <= state_next;
      if (accept) begin
        cnt     <= '0;
        rd_en_q <= 1'b0;
      end else if (state == S_SCAN) begin
        cnt     <= cnt + CNT_W'(1);
        rd_en_q <= (cnt != LAST);
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ARENA: begin
            arena_bytes <= arena_new;
            free_valid  <= CHUNK_SLOTS'(arena_new != '0);
            used_valid  <= '0;
            fresh       <= 1'b1;
            used_total  <= '0;
            free_total  <= arena_new;
            used_cnt    <= '0;
            free_cnt    <= CNT_W'(arena_new != '0);
          end
          REG_ALIGN: begin
            align_log2 <= cfg_data[ALIGN_W-1:0];
          end
          default: begin
            align_log2 <= align_log2;
          end
        endcase
      end
      if (commit) begin
        used_total <= used_total_next;
        free_total <= free_total_next;
        used_cnt   <= used_cnt_next;
        free_cnt   <= free_cnt_next;
        if (fv_we) begin
          free_valid[fv_idx] <= fv_val;
        end
        if (uv_we) begin
          used_valid[uv_idx] <= uv_val;
        end
        if (free_we && free_waddr == '0) begin
          fresh <= 1'b0;
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_free <= (req_type == REQ_FREE);
      sz_q     <= sz_calc;
      fb_q     <= BASE_W'(req_addr);
      fits_q   <= ((AX_W'(req_addr) >> BASE_W) == '0);
    end
    if (state == S_SCAN) begin
      rd_idx_q <= rd_addr;
    end
    if (state == S_CALC) begin
      alloc_addr <= LEN_W'(best_base) + best_len - LEN_W'(sz_q);
      alloc_rem  <= best_len - LEN_W'(sz_q);
      join_prev  <= flags.prev_hit && (LEN_W'(prev_base) + prev_len == LEN_W'(fb_q));
      join_next  <= flags.next_hit && (LEN_W'(fb_q) + match_len == LEN_W'(next_base));
    end
    if (commit) begin
      status     <= st;
      addr_out   <= (st == ST_OK && !req_free) ? ADDR_W'(alloc_addr) : '0;
      used_bytes <= BYTES_W'(used_total_next);
      free_bytes <= BYTES_W'(free_total_next);
      used_count <= COUNT_W'(used_cnt_next);
      free_count <= COUNT_W'(free_cnt_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_used_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(used_valid) == int'(used_cnt))
    else $error("Used chunk count disagrees with the used valid bits.");

  a_free_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(free_valid) == int'(free_cnt))
    else $error("Free chunk count disagrees with the free valid bits.");

  a_bytes: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(used_total) + SUM_W'(free_total) == SUM_W'(arena_bytes))
    else $error("Used and free byte totals do not add up to the arena size.");
`endif

endmodule

/* bench/first_fit_arena_allocator_tb.sv */
`timescale 1ns / 1ps

module first_fit_arena_allocator_tb;
  import ffa_pkg::*;

  localparam int SLOTS = DEF_CHUNK_SLOTS;
  localparam int LATENCY = SLOTS + 3;
  localparam int SPAN_BYTES = 1 << DEF_OFFSET_BITS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 500;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [BYTES_W-1:0]  used_bytes;
    logic [BYTES_W-1:0]  free_bytes;
    logic [COUNT_W-1:0]  used_count;
    logic [COUNT_W-1:0]  free_count;
  } arena_word_t;

  class arena_ledger;
    longint unsigned free_base [SLOTS];
    longint unsigned free_len [SLOTS];
    bit              free_valid [SLOTS];
    longint unsigned used_base [SLOTS];
    longint unsigned used_len [SLOTS];
    bit              used_valid [SLOTS];
    longint unsigned used_total;
    longint unsigned arena_limit;
    int unsigned     align_shift;
    arena_word_t     owed_words [$];
    int              failures;
    int              words_checked;
    int              requests;
    int              status_seen [8];

    function new();
      arena_limit = ARENA_RESET;
      align_shift = ALIGN_RESET;
      clear_tables();
    endfunction

    function void clear_tables();
      for (int i = 0; i < SLOTS; i++) begin
        free_base[i] = 0;
        free_len[i] = 0;
        free_valid[i] = 1'b0;
        used_base[i] = 0;
        used_len[i] = 0;
        used_valid[i] = 1'b0;
      end
      used_total = 0;
      if (arena_limit != 0) begin
        free_len[0] = arena_limit;
        free_valid[0] = 1'b1;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ARENA) begin
        arena_limit = (data > SPAN_BYTES) ? longint'(SPAN_BYTES) : longint'(data);
        clear_tables();
      end else if (idx == REG_ALIGN) begin
        align_shift = data[ALIGN_W-1:0];
      end
    endfunction

    function int first_clear(bit in_used);
      for (int i = 0; i < SLOTS; i++) begin
        if (in_used ? !used_valid[i] : !free_valid[i]) return i;
      end
      return -1;
    endfunction

    function logic [STATUS_W-1:0] carve(longint unsigned size, output longint unsigned base);
      longint unsigned step;
      longint unsigned sz;
      int best;
      int u;
      base = 0;
      best = -1;
      step = 64'd1 << align_shift;
      sz = (size + step - 1) & ~(step - 1);
      if (sz == 0) return ST_ZERO_SIZE;
      for (int i = 0; i < SLOTS; i++) begin
        if (free_valid[i] && free_len[i] >= sz &&
            (best < 0 || free_base[i] < free_base[best])) best = i;
      end
      if (best < 0) return ST_NO_FIT;
      u = first_clear(1'b1);
      if (u < 0) return ST_TABLE_FULL;
      base = free_base[best] + free_len[best] - sz;
      used_base[u] = base;
      used_len[u] = sz;
      used_valid[u] = 1'b1;
      used_total += sz;
      free_len[best] -= sz;
      if (free_len[best] == 0) free_valid[best] = 1'b0;
      return ST_OK;
    endfunction

    function logic [STATUS_W-1:0] give_back(longint unsigned at);
      int u;
      int prev;
      int next;
      int s;
      longint unsigned fb;
      longint unsigned fl;
      bit joinp;
      bit joinn;
      u = -1;
      prev = -1;
      next = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (used_valid[i] && used_base[i] == at) begin
          u = i;
          break;
        end
      end
      if (u < 0) return ST_BAD_FREE;
      fb = used_base[u];
      fl = used_len[u];
      for (int i = 0; i < SLOTS; i++) begin
        if (free_valid[i]) begin
          if (free_base[i] <= fb) begin
            if (prev < 0 || free_base[i] > free_base[prev]) prev = i;
          end else begin
            if (next < 0 || free_base[i] < free_base[next]) next = i;
          end
        end
      end
      joinp = prev >= 0 && free_base[prev] + free_len[prev] == fb;
      joinn = next >= 0 && fb + fl == free_base[next];
      if (joinp) begin
        free_len[prev] += fl;
        if (joinn) begin
          free_len[prev] += free_len[next];
          free_valid[next] = 1'b0;
        end
      end else if (joinn) begin
        free_base[next] = fb;
        free_len[next] += fl;
      end else begin
        s = first_clear(1'b0);
        if (s < 0) return ST_TABLE_FULL;
        free_base[s] = fb;
        free_len[s] = fl;
        free_valid[s] = 1'b1;
      end
      used_valid[u] = 1'b0;
      used_total -= fl;
      return ST_OK;
    endfunction

    function void note_request(logic kind, logic [REQ_SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] at);
      arena_word_t w;
      longint unsigned base;
      longint unsigned fsum;
      int ucnt;
      int fcnt;
      base = 0;
      fsum = 0;
      ucnt = 0;
      fcnt = 0;
      if (kind == REQ_ALLOC) w.status = carve(size, base);
      else w.status = give_back(at);
      if (w.status != ST_OK) base = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (free_valid[i]) begin
          fsum += free_len[i];
          fcnt++;
        end
        if (used_valid[i]) ucnt++;
      end
      w.addr = base[ADDR_W-1:0];
      w.used_bytes = used_total[BYTES_W-1:0];
      w.free_bytes = fsum[BYTES_W-1:0];
      w.used_count = ucnt[COUNT_W-1:0];
      w.free_count = fcnt[COUNT_W-1:0];
      owed_words.push_back(w);
      requests++;
    endfunction

    function void check_word(arena_word_t got);
      arena_word_t want;
      if (owed_words.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("Result word with nothing outstanding: status %0d addr %h", got.status,
                   got.addr);
        return;
      end
      want = owed_words.pop_front();
      words_checked++;
      status_seen[want.status]++;
      if (got.status !== want.status || got.addr !== want.addr ||
          got.used_bytes !== want.used_bytes || got.free_bytes !== want.free_bytes ||
          got.used_count !== want.used_count || got.free_count !== want.free_count) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("Word %0d expected: status %0d addr %h used %0d free %0d counts %0d/%0d",
                   words_checked, want.status, want.addr, want.used_bytes, want.free_bytes,
                   want.used_count, want.free_count);
          $display("Word %0d actual:   status %0d addr %h used %0d free %0d counts %0d/%0d",
                   words_checked, got.status, got.addr, got.used_bytes, got.free_bytes,
                   got.used_count, got.free_count);
        end
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function bit pick_live(output logic [ADDR_W-1:0] base);
      int slots [$];
      base = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (used_valid[i]) slots.push_back(i);
      end
      if (slots.size() == 0) return 1'b0;
      base = used_base[slots[$urandom_range(0, slots.size() - 1)]][ADDR_W-1:0];
      return 1'b1;
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   req_type = REQ_ALLOC;
  logic [REQ_SIZE_W-1:0]  req_size = '0;
  logic [ADDR_W-1:0]      req_addr = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [ADDR_W-1:0]      addr_out;
  logic [BYTES_W-1:0]     used_bytes;
  logic [BYTES_W-1:0]     free_bytes;
  logic [COUNT_W-1:0]     used_count;
  logic [COUNT_W-1:0]     free_count;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  arena_ledger ledger = new;
  bit          quiet = 1'b0;
  int          cycles = 0;
  int          settings = 0;
  int          stall_left = 0;

  first_fit_arena_allocator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .req_size(req_size),
    .req_addr(req_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .addr_out(addr_out),
    .used_bytes(used_bytes),
    .free_bytes(free_bytes),
    .used_count(used_count),
    .free_count(free_count),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d words outstanding.", cycles,
               ledger.pending());
      $display("FAIL first_fit_arena_allocator");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    int r;
    if (!rst && out_valid && !out_stall)
      ledger.check_word({status, addr_out, used_bytes, free_bytes, used_count, free_count});
    if (quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        stall_left = $urandom_range(1, 20);
        out_stall <= 1'b0;
      end else if (r < 90) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic kind, input logic [REQ_SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] at);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type <= kind;
    req_size <= size;
    req_addr <= at;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    ledger.note_request(kind, size, at);
  endtask

  task automatic alloc(input logic [REQ_SIZE_W-1:0] size);
    send_request(REQ_ALLOC, size, ADDR_W'($urandom));
  endtask

  task automatic free_at(input logic [ADDR_W-1:0] at);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), at);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    ledger.write_reg(idx, data);
    settings++;
  endtask

  initial begin
    int r;
    int phase_items;
    int random_sent;
    int size_cap;
    logic [CFG_DATA_W-1:0] arena;
    logic [ADDR_W-1:0] live;
    logic [ADDR_W-1:0] last_freed;
    random_sent = 0;
    last_freed = '0;
    live = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default arena: zero size, no fit, then each way a freed chunk can rejoin free space.
    alloc('0);
    alloc('1);
    alloc(1);
    alloc(100);
    alloc(48);
    free_at('1);
    free_at(ADDR_W'(ARENA_RESET - 16));
    free_at(ADDR_W'(ARENA_RESET - 16));
    free_at(ADDR_W'(ARENA_RESET - 128));
    free_at(ADDR_W'(ARENA_RESET - 176));
    alloc(16);
    alloc(16);
    free_at(ADDR_W'(ARENA_RESET - 32));
    free_at(ADDR_W'(ARENA_RESET - 16));

    // Oversized arena value saturates; coarsest alignment.
    write_register(REG_ALIGN, 15);
    write_register(REG_ARENA, '1);
    alloc('1);
    alloc(REQ_SIZE_W'(SPAN_BYTES));
    alloc(1);
    free_at('0);

    write_register(REG_ARENA, '0);
    alloc(1);
    free_at('0);

    // Fill the used table with single-byte chunks.
    write_register(REG_ALIGN, 0);
    write_register(REG_ARENA, CFG_DATA_W'(SLOTS + 1));
    repeat (SLOTS + 1) alloc(1);
    free_at(ADDR_W'(SLOTS));

    while (random_sent < RANDOM_ITEMS) begin
      phase_items = $urandom_range(20, 70);
      r = $urandom_range(0, 99);
      if (r < 60) arena = CFG_DATA_W'($urandom_range(16, 2048));
      else if (r < 80) arena = CFG_DATA_W'($urandom_range(2049, SPAN_BYTES));
      else if (r < 88) arena = CFG_DATA_W'(SPAN_BYTES);
      else if (r < 93)
        arena = CFG_DATA_W'($urandom_range(SPAN_BYTES + 1, (1 << CFG_DATA_W) - 1));
      else arena = CFG_DATA_W'($urandom_range(0, 8));
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 99);
        if (r < 70) write_register(REG_ALIGN, CFG_DATA_W'($urandom_range(0, 4)));
        else if (r < 90) write_register(REG_ALIGN, CFG_DATA_W'($urandom_range(5, 12)));
        else write_register(REG_ALIGN, CFG_DATA_W'($urandom_range(13, 15)));
      end
      write_register(REG_ARENA, arena);
      quiet = ($urandom_range(0, 3) == 0);
      size_cap = ((arena > SPAN_BYTES) ? SPAN_BYTES : int'(arena)) / 6;
      if (size_cap < 1) size_cap = 1;
      repeat (phase_items) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          alloc((r < 2) ? '0 : REQ_SIZE_W'($urandom));
        end else if (r < 52 || !ledger.pick_live(live)) begin
          alloc(REQ_SIZE_W'($urandom_range(1, size_cap)));
        end else if (r < 88) begin
          free_at(live);
          last_freed = live;
        end else if (r < 94) begin
          free_at(last_freed);
        end else if (r < 97) begin
          free_at(live + 1'b1);
        end else begin
          free_at(ADDR_W'($urandom));
        end
        random_sent++;
      end
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    $display("Checked %0d result words from %0d requests over %0d register writes.",
             ledger.words_checked, ledger.requests, settings);
    $display("Outcomes: ok %0d, zero size %0d, no fit %0d, bad free %0d, table full %0d.",
             ledger.status_seen[ST_OK], ledger.status_seen[ST_ZERO_SIZE],
             ledger.status_seen[ST_NO_FIT], ledger.status_seen[ST_BAD_FREE],
             ledger.status_seen[ST_TABLE_FULL]);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("PASS first_fit_arena_allocator");
    end else begin
      $display("FAIL first_fit_arena_allocator");
    end
    $finish;
  end

endmodule
